FILE: rtl/wrms_pkg.sv
// Package for the weighted RMS error norm block.
// Holds shared widths, reset values, register indexes and the controller/datapath command types.
`timescale 1ns / 1ps
package wrms_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned MaxElements = 65536;
	localparam logic [31:0] AbsTolReset = 32'd4295;
	localparam logic [31:0] RelTolReset = 32'd4295;
	localparam logic [0:0] RegAbsTol = 1'b0;
	localparam logic [0:0] RegRelTol = 1'b1;
	localparam logic [31:0] OneQ16 = 32'h0001_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // Capture an input beat and form the two parts of the scale.
		logic div_init;  // Start the ratio division.
		logic div_step;  // One restoring division step.
		logic accum;     // Add the squared ratio into the sum.
		logic mean_init; // Start the mean division.
		logic mean_step; // One mean division step.
		logic sqrt_init; // Start the square root.
		logic sqrt_step; // One square root step.
		logic emit;      // Load the output register and clear the state.
	} wrms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
		logic step_done;
	} wrms_sts_t;
endpackage

FILE: rtl/wrms_datapath.sv
// Datapath of the weighted RMS error norm block: scale, ratio divider, sum, mean, square root.
// Depends on wrms_pkg for command and status types.
`timescale 1ns / 1ps
module wrms_datapath #(
	parameter int unsigned MAX_ELEMENTS = wrms_pkg::MaxElements
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wrms_pkg::wrms_cmd_t cmd,
	output wrms_pkg::wrms_sts_t sts,
	input  logic [31:0]         abs_tol_q,
	input  logic [31:0]         rel_tol_q,
	input  logic signed [31:0]  value_a,
	input  logic signed [31:0]  value_b,
	input  logic                last,
	output logic [31:0]         rms_q,
	output logic                sat_out_q
);
	localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

	logic [32:0] mag_a, mag_b, mag_max, diff_mag;
	logic signed [32:0] diff;
	logic [31:0] d_q;
	logic        last_q;
	logic [63:0] prod_q, scale_q;
	logic [63:0] rem_q, quo_q;
	logic [5:0]  step_q;
	logic [63:0] sum_q;
	logic [CntW-1:0] cnt_q;
	logic        sat_q;
	logic [63:0] ratio_sq_q;
	logic [63:0] sqrt_x_q;
	logic [31:0] root_q;
	logic [31:0] ratio;

	// Magnitudes of the input beat.
	always_comb begin
		mag_a = value_a[31] ? 33'(-{value_a[31], value_a}) : {1'b0, value_a};
		mag_b = value_b[31] ? 33'(-{value_b[31], value_b}) : {1'b0, value_b};
		mag_max = (mag_a > mag_b) ? mag_a : mag_b;
		diff = {value_a[31], value_a} - {value_b[31], value_b};
		diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
	end

	// Full scale and the check for a ratio that cannot fit.
	logic [63:0] scale_sum;
	logic [63:0] num_init;
	logic        div_sat;
	always_comb begin
		scale_sum = scale_q + prod_q;
		num_init = {16'd0, d_q, 16'd0};
		div_sat = (scale_sum == 64'd0) || (num_init >= scale_sum);
	end

	// Division step operands.
	logic [64:0] rem_sh;
	logic [63:0] div_den;
	logic        take;
	always_comb begin
		div_den = cmd.mean_step ? {{(64-CntW){1'b0}}, cnt_q} : scale_q;
		rem_sh = {rem_q, quo_q[63]};
		if (!cmd.mean_step) rem_sh = {rem_q, 1'b0};
		take = rem_sh >= {1'b0, div_den};
	end

	// Square root trial.
	logic [31:0] trial;
	logic [63:0] trial_sq;
	always_comb begin
		trial = root_q | (32'd1 << step_q[4:0]);
		trial_sq = trial * trial;
	end

	// The count stops at the element limit.
	logic cnt_full;
	assign cnt_full = !(cnt_q < CntW'(MAX_ELEMENTS));

	assign ratio = quo_q[31:0];
	assign sts.last = last_q;
	assign sts.step_done = (step_q == 6'd0);

	logic [64:0] sum_add;
	assign sum_add = {1'b0, sum_q} + {1'b0, ratio_sq_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			sat_q <= 1'b0;
			step_q <= '0;
			last_q <= 1'b0;
			sat_out_q <= 1'b0;
			d_q <= '0;
			prod_q <= '0;
			scale_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			sqrt_x_q <= '0;
			root_q <= '0;
			rms_q <= '0;
		end else begin
			if (cmd.load) begin
				d_q <= diff_mag[31:0];
				last_q <= last;
				prod_q <= rel_tol_q * mag_max[31:0];
				scale_q <= {16'd0, abs_tol_q, 16'd0};
			end
			if (cmd.div_init) begin
				scale_q <= scale_sum;
				rem_q <= num_init;
				if (div_sat) begin
					sat_q <= 1'b1;
					step_q <= 6'd0;
					quo_q <= 64'h0000_0000_FFFF_FFFF;
				end else begin
					step_q <= 6'd32;
					quo_q <= '0;
				end
			end
			if (cmd.div_step) begin
				if (rem_q[63] || take) rem_q <= 64'(rem_sh - {1'b0, scale_q});
				else rem_q <= rem_sh[63:0];
				quo_q <= {quo_q[62:0], rem_q[63] | take};
				step_q <= step_q - 6'd1;
			end
			if (cmd.accum) begin
				sum_q <= sum_add[64] ? '1 : sum_add[63:0];
				sat_q <= sat_q | sum_add[64] | cnt_full;
				if (!cnt_full) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.mean_init) begin
				quo_q <= sum_q;
				rem_q <= '0;
				step_q <= 6'd63;
			end
			if (cmd.mean_step) begin
				rem_q <= take ? 64'(rem_sh - {1'b0, div_den}) : rem_sh[63:0];
				quo_q <= {quo_q[62:0], take};
				step_q <= step_q - 6'd1;
			end
			if (cmd.sqrt_init) begin
				sqrt_x_q <= quo_q;
				root_q <= '0;
				step_q <= 6'd31;
			end
			if (cmd.sqrt_step) begin
				if (trial_sq <= sqrt_x_q) root_q <= trial;
				step_q <= step_q - 6'd1;
			end
			if (cmd.emit) begin
				rms_q <= root_q;
				sat_out_q <= sat_q;
				sum_q <= '0;
				cnt_q <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	// Square of the ratio, registered ahead of the accumulation.
	always_ff @(posedge clk) begin
		ratio_sq_q <= ratio * ratio;
	end
endmodule

FILE: rtl/wrms_ctrl.sv
// Controller of the weighted RMS error norm block: sequences load, divide, accumulate, mean, root.
// Depends on wrms_pkg for command and status types.
`timescale 1ns / 1ps
module wrms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  wrms_pkg::wrms_sts_t sts,
	output wrms_pkg::wrms_cmd_t cmd
);
	localparam logic [3:0] StIdle = 4'd0, StScale = 4'd1, StDiv = 4'd2, StSq = 4'd3,
		StAcc = 4'd4, StMean = 4'd5, StMeanRun = 4'd6, StSqrtInit = 4'd7,
		StSqrt = 4'd8, StEmit = 4'd9, StProd = 4'd10, StLast = 4'd11;

	logic [3:0] state_q;
	logic       out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == StIdle);

	always_comb begin
		cmd = '0;
		case (state_q)
			StIdle:     cmd.load = in_valid;
			StProd:     cmd.div_init = 1'b1;
			StDiv:      cmd.div_step = !sts.step_done;
			StAcc:      cmd.accum = 1'b1;
			StMean:     cmd.mean_init = 1'b1;
			StMeanRun:  cmd.mean_step = 1'b1;
			StSqrtInit: cmd.sqrt_init = 1'b1;
			StSqrt:     cmd.sqrt_step = 1'b1;
			StEmit:     cmd.emit = !out_valid_q || out_ready;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one taken in the same cycle.
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				StIdle:     if (in_valid) state_q <= StScale;
				StScale:    state_q <= StProd;
				StProd:     state_q <= StDiv;
				StDiv:      if (sts.step_done) state_q <= StSq;
				StSq:       state_q <= StAcc;
				StAcc:      state_q <= sts.last ? StMean : StIdle;
				StMean:     state_q <= StMeanRun;
				StMeanRun:  if (sts.step_done) state_q <= StLast;
				StLast:     state_q <= StSqrtInit;
				StSqrtInit: state_q <= StSqrt;
				StSqrt:     if (sts.step_done) state_q <= StEmit;
				StEmit:     if (cmd.emit) state_q <= StIdle;
				default:    state_q <= StIdle;
			endcase
		end
	end
endmodule

FILE: rtl/weighted_rms_error_norm.sv
// Top level of the weighted RMS error norm block.
// Depends on wrms_pkg, wrms_ctrl and wrms_datapath.
`timescale 1ns / 1ps
// Each beat of a Q16.16 pair passes through the 32-step restoring divider that
// forms |a-b|/scale; the beat marked last then also runs the 64-step mean divider
// and the 32-step square root. One beat is in work at a time, and the result sits
// in an output register until it is taken.
module weighted_rms_error_norm #(
	parameter int unsigned MAX_ELEMENTS = wrms_pkg::MaxElements
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value_a,
	input  logic signed [31:0] value_b,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        rms_error,
	output logic               within_tolerance,
	output logic               saturated
);
	logic [31:0] abs_tol_q, rel_tol_q;
	wrms_pkg::wrms_cmd_t cmd;
	wrms_pkg::wrms_sts_t sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_tol_q <= wrms_pkg::AbsTolReset;
			rel_tol_q <= wrms_pkg::RelTolReset;
		end else if (cfg_we) begin
			if (cfg_index == wrms_pkg::RegAbsTol) abs_tol_q <= cfg_data;
			if (cfg_index == wrms_pkg::RegRelTol) rel_tol_q <= cfg_data;
		end
	end

	wrms_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	wrms_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .abs_tol_q, .rel_tol_q,
		.value_a, .value_b, .last, .rms_q(rms_error), .sat_out_q(saturated)
	);

	assign within_tolerance = rms_error < wrms_pkg::OneQ16;
endmodule

FILE: rtl/wrms_checker.sv
// Port-level checker for the weighted RMS error norm block, bound to the top level.
// Depends on wrms_pkg only through the bound module.
`timescale 1ns / 1ps
module wrms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] rms_error,
	input logic        within_tolerance
);
	// A pending result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rms_error)) else $error("result changed");
	// The flag agrees with the value.
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> within_tolerance == (rms_error < 32'h10000)) else $error("flag wrong");
	// Taking a beat makes the block busy next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	// No result appears in the cycle right after a beat is taken.
	a_norush: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid) else $error("early result");
endmodule

bind weighted_rms_error_norm wrms_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .rms_error, .within_tolerance
);
